// ===== rtl/mhv_pkg.sv =====
// Shared types and constants for the model header validator.
`timescale 1ns / 1ps
`default_nettype none

package mhv_pkg;

    // Result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_SIG     = 3'd1;
    localparam logic [2:0] ST_TRUNCATED   = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION = 3'd3;
    localparam logic [2:0] ST_BAD_GLOBALS = 3'd4;
    localparam logic [2:0] ST_BAD_ENCODE  = 3'd5;
    localparam logic [2:0] ST_BAD_INDEX   = 3'd6;

    localparam logic [31:0] VER_2_0 = 32'h4000_0000;
    localparam logic [31:0] VER_2_1 = 32'h4006_6666;

    localparam logic [7:0] MIN_GLOBALS = 8'd8;
    localparam int         NUM_INDEX   = 6;

    // Field start offsets
    localparam logic [8:0] OFF_SIG     = 9'd0;
    localparam logic [8:0] OFF_VERSION = 9'd4;
    localparam logic [8:0] OFF_COUNT   = 9'd8;
    localparam logic [8:0] OFF_GLOBALS = 9'd9;

    typedef struct packed {
        logic [2:0]                 status;
        logic [8:0]                 error_offset;
        logic                       version_2_1;
        logic                       text_encoding;
        logic [2:0]                 extra_vec4_count;
        logic [NUM_INDEX-1:0][2:0]  index_size;
        logic [7:0]                 unknown_globals;
    } result_t;

    // Expected signature "PMX "
    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h50;
            2'd1:    b = 8'h4D;
            2'd2:    b = 8'h58;
            default: b = 8'h20;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mhv_parser.sv =====
// Header parse state machine: one byte per step, emits at most one result per file.
`timescale 1ns / 1ps
`default_nettype none

module mhv_parser
    import mhv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output logic            push,
    output result_t         result
);

    typedef enum logic [1:0] {
        PH_SIG,
        PH_VER,
        PH_COUNT,
        PH_GLOBALS
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [8:0]                 pos_reg, pos_next;
    logic [31:0]                ver_reg, ver_next;
    logic [7:0]                 glob_reg, glob_next;
    logic [2:0]                 pend_reg, pend_next;
    logic [8:0]                 poff_reg, poff_next;
    logic                       enc_reg, enc_next;
    logic [2:0]                 vec4_reg, vec4_next;
    logic [NUM_INDEX-1:0][2:0]  idx_reg, idx_next;
    logic                       sent_reg, sent_next;

    logic       emit;
    logic [2:0] st;
    logic [8:0] off;
    logic [8:0] pos_m4;
    logic [8:0] pos_m9;
    logic [7:0] gi;
    logic [2:0] slot;
    logic       keep;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        ver_next   = ver_reg;
        glob_next  = glob_reg;
        pend_next  = pend_reg;
        poff_next  = poff_reg;
        enc_next   = enc_reg;
        vec4_next  = vec4_reg;
        idx_next   = idx_reg;
        sent_next  = sent_reg;
        emit       = 1'b0;
        st         = ST_OK;
        off        = OFF_SIG;
        pos_m4     = pos_reg - 9'd4;
        pos_m9     = pos_reg - 9'd9;
        gi         = pos_m9[7:0];
        slot       = gi[2:0] - 3'd2;
        keep       = 1'b1;
        result     = '0;

        if (step && !sent_reg)
        begin
            case (phase_reg)
                PH_SIG:
                begin
                    if (data_byte != sig_byte(pos_reg[1:0]))
                    begin
                        emit = 1'b1;
                        st   = ST_BAD_SIG;
                        off  = OFF_SIG;
                    end
                    else if (pos_reg >= 9'd3)
                    begin
                        phase_next = PH_VER;
                    end
                end
                PH_VER:
                begin
                    ver_next = ver_reg | (32'(data_byte) << {pos_m4[1:0], 3'b000});
                    if (pos_reg >= 9'd7)
                    begin
                        if (ver_next != VER_2_0 && ver_next != VER_2_1)
                        begin
                            emit = 1'b1;
                            st   = ST_BAD_VERSION;
                            off  = OFF_VERSION;
                        end
                        else
                        begin
                            phase_next = PH_COUNT;
                        end
                    end
                end
                PH_COUNT:
                begin
                    glob_next = data_byte;
                    if (data_byte < MIN_GLOBALS)
                    begin
                        emit = 1'b1;
                        st   = ST_BAD_GLOBALS;
                        off  = OFF_COUNT;
                    end
                    else
                    begin
                        phase_next = PH_GLOBALS;
                    end
                end
                default:
                begin
                    if (pend_reg == ST_OK)
                    begin
                        if (gi == 8'd0)
                        begin
                            if (data_byte > 8'd1)
                            begin
                                pend_next = ST_BAD_ENCODE;
                                poff_next = pos_reg;
                            end
                            else
                            begin
                                enc_next = data_byte[0];
                            end
                        end
                        else if (gi == 8'd1)
                        begin
                            if (data_byte > 8'd4)
                            begin
                                pend_next = ST_BAD_GLOBALS;
                                poff_next = pos_reg;
                            end
                            else
                            begin
                                vec4_next = data_byte[2:0];
                            end
                        end
                        else if (gi < 8'd8)
                        begin
                            if (data_byte != 8'd1 && data_byte != 8'd2 && data_byte != 8'd4)
                            begin
                                pend_next = ST_BAD_INDEX;
                                poff_next = pos_reg;
                            end
                            else
                            begin
                                idx_next[slot] = data_byte[2:0];
                            end
                        end
                    end
                    if ((9'(gi) + 9'd1) >= 9'(glob_reg))
                    begin
                        emit = 1'b1;
                        st   = pend_next;
                        off  = (pend_next != ST_OK) ? poff_next : OFF_SIG;
                    end
                end
            endcase

            if (!emit)
            begin
                pos_next = pos_reg + 9'd1;
                if (last_byte)
                begin
                    emit = 1'b1;
                    st   = ST_TRUNCATED;
                    case (phase_next)
                        PH_SIG:   off = OFF_SIG;
                        PH_VER:   off = OFF_VERSION;
                        PH_COUNT: off = OFF_COUNT;
                        default:  off = OFF_GLOBALS;
                    endcase
                end
            end

            if (emit)
            begin
                sent_next = 1'b1;
            end
        end

        // Result built from the post-update state
        keep                     = (st != ST_TRUNCATED);
        result.status            = st;
        result.error_offset      = off;
        result.version_2_1       = (phase_next == PH_COUNT || phase_next == PH_GLOBALS)
                                   && (ver_next == VER_2_1);
        result.text_encoding     = keep ? enc_next : 1'b0;
        result.extra_vec4_count  = keep ? vec4_next : 3'd0;
        result.index_size        = keep ? idx_next : '0;
        result.unknown_globals   = (st == ST_OK) ? (glob_next - MIN_GLOBALS) : 8'd0;

        // Final byte of a file rearms the parser
        if (step && last_byte)
        begin
            phase_next = PH_SIG;
            pos_next   = '0;
            ver_next   = '0;
            glob_next  = '0;
            pend_next  = ST_OK;
            poff_next  = '0;
            enc_next   = 1'b0;
            vec4_next  = '0;
            idx_next   = '0;
            sent_next  = 1'b0;
        end
    end

    assign push = emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIG;
            pos_reg   <= '0;
            ver_reg   <= '0;
            glob_reg  <= '0;
            pend_reg  <= ST_OK;
            poff_reg  <= '0;
            enc_reg   <= 1'b0;
            vec4_reg  <= '0;
            idx_reg   <= '0;
            sent_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            ver_reg   <= ver_next;
            glob_reg  <= glob_next;
            pend_reg  <= pend_next;
            poff_reg  <= poff_next;
            enc_reg   <= enc_next;
            vec4_reg  <= vec4_next;
            idx_reg   <= idx_next;
            sent_reg  <= sent_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mhv_out_queue.sv =====
// Two-entry result queue: output register plus skid slot.
`timescale 1ns / 1ps
`default_nettype none

module mhv_out_queue
    import mhv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         room,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      head
);

    logic [1:0] cnt_reg, cnt_next;
    result_t    head_reg;
    result_t    tail_reg;
    logic       pop;

    assign pop       = (cnt_reg != 2'd0) && !out_stall;
    assign room      = (cnt_reg != 2'd2) || pop;
    assign out_valid = (cnt_reg != 2'd0);
    assign head      = head_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && pop)
        begin
            if (cnt_reg == 2'd1)
            begin
                head_reg <= push_data;
            end
            else
            begin
                head_reg <= tail_reg;
                tail_reg <= push_data;
            end
        end
        else if (pop)
        begin
            head_reg <= tail_reg;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                head_reg <= push_data;
            end
            else
            begin
                tail_reg <= push_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/model_header_validator.sv =====
// Top level of the model header validator: input register, parser, result queue.
// Timing: an accepted byte waits in the input register and steps the parser when a result
//   slot is free; a result it causes is pushed into the queue on that step and leaves from its head.
// Throughput: one byte per cycle; the input stalls only when both result slots
//   are full and the head is not being taken.
// Reset (rst_n low, asynchronous): all empty, parser at the signature; last_byte rearms.
`timescale 1ns / 1ps
`default_nettype none

module model_header_validator
    import mhv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      status,
    output logic [8:0]      error_offset,
    output logic            version_2_1,
    output logic            text_encoding,
    output logic [2:0]      extra_vec4_count,
    output logic [2:0]      vertex_index_size,
    output logic [2:0]      texture_index_size,
    output logic [2:0]      material_index_size,
    output logic [2:0]      bone_index_size,
    output logic [2:0]      morph_index_size,
    output logic [2:0]      rigid_body_index_size,
    output logic [7:0]      unknown_globals
);

    // Input register: holds one item until the parser can step on it
    logic       in_vld_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic       room;
    logic       advance;
    logic       push;
    result_t    res;
    result_t    head;

    // Parser steps whenever the queue can take a possible result
    assign advance  = in_vld_reg && room;
    assign in_stall = in_vld_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    mhv_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (byte_reg),
        .last_byte (last_reg),
        .push      (push),
        .result    (res)
    );

    // Result register plus skid slot, so bytes keep flowing while a result waits
    mhv_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push && advance),
        .push_data (res),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign status                = head.status;
    assign error_offset          = head.error_offset;
    assign version_2_1           = head.version_2_1;
    assign text_encoding         = head.text_encoding;
    assign extra_vec4_count      = head.extra_vec4_count;
    assign vertex_index_size     = head.index_size[0];
    assign texture_index_size    = head.index_size[1];
    assign material_index_size   = head.index_size[2];
    assign bone_index_size       = head.index_size[3];
    assign morph_index_size      = head.index_size[4];
    assign rigid_body_index_size = head.index_size[5];
    assign unknown_globals       = head.unknown_globals;

endmodule

`default_nettype wire

// ===== sim/mhv_checker.sv =====
// Checker for the model header validator: predicts each header result and compares it.
`timescale 1ns / 1ps

module mhv_checker
    import mhv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [2:0] status,
    input  wire logic [8:0] error_offset,
    input  wire logic       version_2_1,
    input  wire logic       text_encoding,
    input  wire logic [2:0] extra_vec4_count,
    input  wire logic [2:0] vertex_index_size,
    input  wire logic [2:0] texture_index_size,
    input  wire logic [2:0] material_index_size,
    input  wire logic [2:0] bone_index_size,
    input  wire logic [2:0] morph_index_size,
    input  wire logic [2:0] rigid_body_index_size,
    input  wire logic [7:0] unknown_globals,
    input  wire logic       run_done,
    output int              fail_count,
    output int              expected_left,
    output int              results_seen,
    output int              errors_seen
);

    typedef enum logic [1:0] {HDR_SIG, HDR_VER, HDR_COUNT, HDR_GLOBALS} hdr_phase_t;

    localparam logic [31:0] SIG_WORD = 32'h504D_5820;   // "PMX ", first byte on top

    hdr_phase_t  phase;
    logic [8:0]  pos;
    logic [31:0] ver_word;
    logic [7:0]  n_globals;
    logic [2:0]  held_err;
    logic [8:0]  held_off;
    logic        enc_flag;
    logic [2:0]  vec4_cnt;
    logic [2:0]  idx_size [NUM_INDEX];
    logic        reported;
    logic        leftover_done;

    result_t header_q[$];

    task automatic clear_header();
        phase     = HDR_SIG;
        pos       = '0;
        ver_word  = '0;
        n_globals = '0;
        held_err  = ST_OK;
        held_off  = '0;
        enc_flag  = 1'b0;
        vec4_cnt  = '0;
        for (int k = 0; k < NUM_INDEX; k++)
            idx_size[k] = '0;
        reported  = 1'b0;
    endtask

    // Truncation drops the decoded globals; only a clean header reports extras.
    task automatic post_header(input logic [2:0] st, input logic [8:0] off);
        result_t r;
        r.status           = st;
        r.error_offset     = off;
        r.version_2_1      = (phase > HDR_VER) && (ver_word == VER_2_1);
        r.text_encoding    = (st != ST_TRUNCATED) ? enc_flag : 1'b0;
        r.extra_vec4_count = (st != ST_TRUNCATED) ? vec4_cnt : 3'd0;
        for (int k = 0; k < NUM_INDEX; k++)
            r.index_size[k] = (st != ST_TRUNCATED) ? idx_size[k] : 3'd0;
        r.unknown_globals  = (st == ST_OK) ? n_globals - MIN_GLOBALS : 8'd0;
        header_q.insert(header_q.size(), r);
        reported = 1'b1;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        logic [7:0] gi;
        if (!reported)
        begin
            case (phase)
                HDR_SIG:
                begin
                    if (b != SIG_WORD[8 * (3 - pos[1:0]) +: 8])
                        post_header(ST_BAD_SIG, OFF_SIG);
                    else if (pos >= 9'd3)
                        phase = HDR_VER;
                end
                HDR_VER:
                begin
                    ver_word[8 * pos[1:0] +: 8] = b;
                    if (pos >= 9'd7)
                    begin
                        if (ver_word != VER_2_0 && ver_word != VER_2_1)
                            post_header(ST_BAD_VERSION, OFF_VERSION);
                        else
                            phase = HDR_COUNT;
                    end
                end
                HDR_COUNT:
                begin
                    n_globals = b;
                    if (b < MIN_GLOBALS)
                        post_header(ST_BAD_GLOBALS, OFF_COUNT);
                    else
                        phase = HDR_GLOBALS;
                end
                default:
                begin
                    gi = 8'(pos - OFF_GLOBALS);
                    // first bad global is held until the block is complete
                    if (held_err == ST_OK)
                    begin
                        if (gi == 8'd0)
                        begin
                            if (b > 8'd1)
                            begin
                                held_err = ST_BAD_ENCODE;
                                held_off = pos;
                            end
                            else
                                enc_flag = b[0];
                        end
                        else if (gi == 8'd1)
                        begin
                            if (b > 8'd4)
                            begin
                                held_err = ST_BAD_GLOBALS;
                                held_off = pos;
                            end
                            else
                                vec4_cnt = b[2:0];
                        end
                        else if (gi < 8'd8)
                        begin
                            if (b != 8'd1 && b != 8'd2 && b != 8'd4)
                            begin
                                held_err = ST_BAD_INDEX;
                                held_off = pos;
                            end
                            else
                                idx_size[3'(gi - 8'd2)] = b[2:0];
                        end
                    end
                    if (int'(gi) + 1 >= int'(n_globals))
                        post_header(held_err, (held_err != ST_OK) ? held_off : 9'd0);
                end
            endcase
            if (!reported)
            begin
                pos = pos + 9'd1;
                if (last)
                begin
                    case (phase)
                        HDR_SIG:   post_header(ST_TRUNCATED, OFF_SIG);
                        HDR_VER:   post_header(ST_TRUNCATED, OFF_VERSION);
                        HDR_COUNT: post_header(ST_TRUNCATED, OFF_COUNT);
                        default:   post_header(ST_TRUNCATED, OFF_GLOBALS);
                    endcase
                end
            end
        end
        if (last)
            clear_header();
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_header();
        result_t want;
        if (header_q.size() == 0)
        begin
            $error("header result with none expected: status %0d offset %0d",
                   status, error_offset);
            fail_count++;
        end
        else
        begin
            want = header_q.pop_front();
            results_seen++;
            if (want.status != ST_OK)
                errors_seen++;
            check_field("status", int'(want.status), int'(status));
            check_field("error_offset", int'(want.error_offset), int'(error_offset));
            check_field("version_2_1", int'(want.version_2_1), int'(version_2_1));
            check_field("text_encoding", int'(want.text_encoding), int'(text_encoding));
            check_field("extra_vec4_count", int'(want.extra_vec4_count),
                        int'(extra_vec4_count));
            check_field("vertex_index_size", int'(want.index_size[0]),
                        int'(vertex_index_size));
            check_field("texture_index_size", int'(want.index_size[1]),
                        int'(texture_index_size));
            check_field("material_index_size", int'(want.index_size[2]),
                        int'(material_index_size));
            check_field("bone_index_size", int'(want.index_size[3]),
                        int'(bone_index_size));
            check_field("morph_index_size", int'(want.index_size[4]),
                        int'(morph_index_size));
            check_field("rigid_body_index_size", int'(want.index_size[5]),
                        int'(rigid_body_index_size));
            check_field("unknown_globals", int'(want.unknown_globals),
                        int'(unknown_globals));
        end
    endtask

    initial
    begin
        fail_count    = 0;
        expected_left = 0;
        results_seen  = 0;
        errors_seen   = 0;
        leftover_done = 1'b0;
        clear_header();
    end

    // Result is taken before the byte: a byte's header can't leave on its own edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_header();
            header_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
                check_header();
            if (in_valid && !in_stall)
                predict_byte(data_byte, last_byte);
            if (run_done && !leftover_done)
            begin
                leftover_done = 1'b1;
                if (header_q.size() != 0)
                begin
                    $error("%0d header results never arrived", header_q.size());
                    fail_count += header_q.size();
                end
            end
        end
        expected_left = header_q.size();
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the model header validator: file stimulus, reset, clock and verdict.
`timescale 1ns / 1ps

module tb
    import mhv_pkg::*;
;

    localparam int IDLE_PCT    = 34;      // chance of a gap before an item / of a stall cycle
    localparam int BYTE_TARGET = 2000;    // random stimulus stops past this many bytes
    localparam int DRAIN_LIMIT = 10000;   // cycles allowed for the last results to land

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] data_byte = 8'd0;
    logic       last_byte = 1'b0;
    logic       out_stall = 1'b0;
    logic       quiet     = 1'b0;     // no idling on either side while set
    logic       run_done  = 1'b0;

    logic       in_stall;
    logic       out_valid;
    logic [2:0] status;
    logic [8:0] error_offset;
    logic       version_2_1;
    logic       text_encoding;
    logic [2:0] extra_vec4_count;
    logic [2:0] vertex_index_size;
    logic [2:0] texture_index_size;
    logic [2:0] material_index_size;
    logic [2:0] bone_index_size;
    logic [2:0] morph_index_size;
    logic [2:0] rigid_body_index_size;
    logic [7:0] unknown_globals;

    int fail_count;
    int expected_left;
    int results_seen;
    int errors_seen;

    // The file under construction, sent byte by byte with last on the final one.
    logic [7:0] file_bytes[$];
    int         bytes_sent = 0;
    int         files_sent = 0;
    int         drain_cycles;

    always #5 clk = ~clk;

    model_header_validator u_dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .data_byte             (data_byte),
        .last_byte             (last_byte),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .status                (status),
        .error_offset          (error_offset),
        .version_2_1           (version_2_1),
        .text_encoding         (text_encoding),
        .extra_vec4_count      (extra_vec4_count),
        .vertex_index_size     (vertex_index_size),
        .texture_index_size    (texture_index_size),
        .material_index_size   (material_index_size),
        .bone_index_size       (bone_index_size),
        .morph_index_size      (morph_index_size),
        .rigid_body_index_size (rigid_body_index_size),
        .unknown_globals       (unknown_globals)
    );

    mhv_checker u_chk (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .data_byte             (data_byte),
        .last_byte             (last_byte),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .status                (status),
        .error_offset          (error_offset),
        .version_2_1           (version_2_1),
        .text_encoding         (text_encoding),
        .extra_vec4_count      (extra_vec4_count),
        .vertex_index_size     (vertex_index_size),
        .texture_index_size    (texture_index_size),
        .material_index_size   (material_index_size),
        .bone_index_size       (bone_index_size),
        .morph_index_size      (morph_index_size),
        .rigid_body_index_size (rigid_body_index_size),
        .unknown_globals       (unknown_globals),
        .run_done              (run_done),
        .fail_count            (fail_count),
        .expected_left         (expected_left),
        .results_seen          (results_seen),
        .errors_seen           (errors_seen)
    );

    // Receiver back-pressure: random stalls except inside the quiet window.
    always @(posedge clk)
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);

    // Appends one byte to the end of the file.
    task automatic add_byte(input logic [7:0] b);
        file_bytes.insert(file_bytes.size(), b);
    endtask

    // A legal value for global k; globals past the eighth are free bytes.
    function automatic logic [7:0] legal_global(input int k);
        logic [7:0] v;
        if (k == 0)
            v = 8'($urandom_range(1));
        else if (k == 1)
            v = 8'($urandom_range(4));
        else if (k < 8)
            v = 8'd1 << $urandom_range(2);
        else
            v = 8'($urandom_range(255));
        return v;
    endfunction

    // An illegal value for one of the eight defined globals.
    function automatic logic [7:0] bad_global(input int k);
        logic [7:0] v;
        if (k == 0)
            v = 8'($urandom_range(2, 255));
        else if (k == 1)
            v = 8'($urandom_range(5, 255));
        else
        begin
            v = 8'($urandom_range(255));
            while (v == 8'd1 || v == 8'd2 || v == 8'd4)
                v = 8'($urandom_range(255));
        end
        return v;
    endfunction

    // Well-formed header: signature, version, count, then legal globals.
    task automatic build_header(input bit v21, input logic [7:0] count);
        logic [31:0] ver;
        ver = v21 ? VER_2_1 : VER_2_0;
        file_bytes.delete();
        for (int k = 0; k < 4; k++)
            add_byte(sig_byte(k[1:0]));
        for (int k = 0; k < 4; k++)
            add_byte(ver[8 * k +: 8]);
        add_byte(count);
        for (int k = 0; k < count; k++)
            add_byte(legal_global(k));
    endtask

    task automatic cut_file(input int len);
        while (file_bytes.size() > len)
            file_bytes.delete(file_bytes.size() - 1);
    endtask

    // Valid is only dropped ahead of a real gap, so it is never lowered and
    // raised again in the same time step.
    task automatic send_file();
        for (int k = 0; k < file_bytes.size(); k++)
        begin
            if (!quiet && $urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while ($urandom_range(99) < IDLE_PCT);
            end
            in_valid  <= 1'b1;
            data_byte <= file_bytes[k];
            last_byte <= (k == file_bytes.size() - 1);
            do
                @(posedge clk);
            while (in_stall);
            bytes_sent++;
        end
        files_sent++;
    endtask

    initial
    begin
        int          kind;
        int          mut;
        int          len;
        int          rand_files;
        int          gi;
        logic [7:0]  count;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed files ----------------
        // clean 2.0 header, smallest globals block
        build_header(1'b0, 8'd8);
        send_file();

        // 2.1, every global at its top legal value, largest globals block
        build_header(1'b1, 8'd255);
        file_bytes[OFF_GLOBALS]     = 8'd1;
        file_bytes[OFF_GLOBALS + 1] = 8'd4;
        for (int k = 2; k < 8; k++)
            file_bytes[OFF_GLOBALS + k] = 8'd4;
        send_file();

        // bottom legal values, then trailing bytes the block must ignore
        build_header(1'b0, 8'd8);
        file_bytes[OFF_GLOBALS]     = 8'd0;
        file_bytes[OFF_GLOBALS + 1] = 8'd0;
        for (int k = 2; k < 8; k++)
            file_bytes[OFF_GLOBALS + k] = 8'd1;
        repeat (3) add_byte(8'hFF);
        send_file();

        // signature broken on the first byte and on the trailing space
        build_header(1'b0, 8'd8);
        file_bytes[0] = 8'h00;
        send_file();
        build_header(1'b1, 8'd9);
        file_bytes[3] = 8'hA0;
        send_file();

        // one-byte file that breaks the signature: an error, not a truncation
        file_bytes.delete();
        add_byte(8'h51);
        send_file();

        // version 2.2, then all ones
        build_header(1'b1, 8'd8);
        file_bytes[OFF_VERSION]     = 8'hCD;
        file_bytes[OFF_VERSION + 1] = 8'hCC;
        file_bytes[OFF_VERSION + 2] = 8'h0C;
        send_file();
        build_header(1'b0, 8'd8);
        for (int k = 0; k < 4; k++)
            file_bytes[OFF_VERSION + k] = 8'hFF;
        send_file();

        // globals count below the minimum, reported on the count byte
        build_header(1'b1, 8'd8);
        file_bytes[OFF_COUNT] = 8'd7;
        send_file();
        build_header(1'b0, 8'd8);
        file_bytes[OFF_COUNT] = 8'd0;
        send_file();

        // bad encoding flag, bad vec4 count, bad index sizes at both ends
        build_header(1'b1, 8'd8);
        file_bytes[OFF_GLOBALS] = 8'd2;
        send_file();
        build_header(1'b0, 8'd10);
        file_bytes[OFF_GLOBALS] = 8'hFF;
        send_file();
        build_header(1'b0, 8'd8);
        file_bytes[OFF_GLOBALS + 1] = 8'd5;
        send_file();
        build_header(1'b1, 8'd8);
        file_bytes[OFF_GLOBALS + 2] = 8'd0;
        send_file();
        build_header(1'b0, 8'd8);
        file_bytes[OFF_GLOBALS + 7] = 8'd3;
        send_file();
        build_header(1'b1, 8'd12);
        file_bytes[OFF_GLOBALS + 4] = 8'hFF;
        send_file();

        // two bad globals: the earlier one is the one reported
        build_header(1'b0, 8'd8);
        file_bytes[OFF_GLOBALS]     = 8'd2;
        file_bytes[OFF_GLOBALS + 7] = 8'd3;
        send_file();

        // early end in each part of the header
        file_bytes.delete();
        add_byte(sig_byte(2'd0));
        send_file();
        build_header(1'b1, 8'd8);
        cut_file(6);
        send_file();
        build_header(1'b1, 8'd8);
        cut_file(8);
        send_file();
        build_header(1'b0, 8'd8);
        cut_file(9);
        send_file();
        // short globals block wins over the bad vec4 count inside it
        build_header(1'b1, 8'd8);
        file_bytes[OFF_GLOBALS + 1] = 8'd9;
        cut_file(13);
        send_file();

        // ---------------- random files ----------------
        // Mostly well-formed headers with random content and one flaw at most (some
        // get two bad globals); a share of pure noise. A run of files goes by with no idling.
        rand_files = 0;
        while (bytes_sent < BYTE_TARGET)
        begin
            quiet <= (rand_files >= 25 && rand_files < 45);
            kind = $urandom_range(99);
            if (kind < 10)
            begin
                file_bytes.delete();
                len = $urandom_range(1, 10);
                for (int k = 0; k < len; k++)
                    add_byte(8'($urandom_range(255)));
                if ($urandom_range(1))
                    file_bytes[0] = sig_byte(2'd0);
            end
            else
            begin
                // large globals blocks are rare to keep files short
                count = ($urandom_range(99) < 90) ? 8'($urandom_range(8, 14))
                                                  : 8'($urandom_range(15, 255));
                build_header(1'($urandom_range(1)), count);
                mut = $urandom_range(99);
                if (mut < 45)
                begin
                    // clean
                end
                else if (mut < 60)
                    file_bytes[$urandom_range(file_bytes.size() - 1)] =
                        8'($urandom_range(255));
                else if (mut < 70)
                begin
                    gi = $urandom_range(7);
                    file_bytes[OFF_GLOBALS + gi] = bad_global(gi);
                    if ($urandom_range(2) == 0)
                    begin
                        gi = $urandom_range(7);
                        file_bytes[OFF_GLOBALS + gi] = bad_global(gi);
                    end
                end
                else if (mut < 80)
                    cut_file($urandom_range(1, file_bytes.size() - 1));
                else if (mut < 85)
                    file_bytes[OFF_COUNT] = 8'($urandom_range(7));
                else if (mut < 92)
                    file_bytes[OFF_VERSION + $urandom_range(3)] ^= 8'd1 << $urandom_range(7);
                else
                    file_bytes[$urandom_range(3)] = 8'($urandom_range(255));
                // trailing bytes after the header
                if ($urandom_range(4) == 0)
                    repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)));
            end
            send_file();
            rand_files++;
        end

        // ---------------- drain and verdict ----------------
        in_valid <= 1'b0;
        quiet    <= 1'b0;
        drain_cycles = 0;
        @(negedge clk);
        while (expected_left != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain_cycles++;
        end
        // results trail their last byte; leave room for stragglers
        repeat (4) @(posedge clk);
        run_done <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Run covered %0d files, %0d bytes: %0d header results checked, %0d errors.",
                 files_sent, bytes_sent, results_seen, errors_seen);
        if (fail_count == 0 && drain_cycles < DRAIN_LIMIT)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of a few thousand bytes.
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
